// ----- hw/rtl/scc_pkg.sv -----
// Shared types for the strongly connected component size block.
// Holds the input and result item structs. No dependencies.
package scc_pkg;

	localparam int FIELD_W = 7;

	typedef struct packed {
		logic [FIELD_W-1:0] tail_vertex;
		logic [FIELD_W-1:0] head_vertex;
		logic               last_edge;
	} edge_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] component_size;
		logic               last_component;
		logic               edges_dropped;
	} result_t;

endpackage

// ----- hw/rtl/scc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/strongly_connected_component_sizes.sv -----
// Top level of the strongly connected component size block (Kosaraju).
// Depends on scc_pkg and scc_ram.
//
// Usage. Edge items enter on the command channel: an item is taken at a rising
// edge with start high and busy low. Each item is stored in two adjacency
// matrices (predecessor rows and successor rows) by a read-modify-write, during
// which busy stays high, so the block cannot take a new item until that write is
// done. Edges with an endpoint of zero or above the vertex count, or arriving with
// the store full, are dropped and remembered in a sticky flag reported with every
// result of the run.
// The item with last_edge set starts the computation: a depth-first pass on the
// reversed graph records finishing order, then a pass on the forward graph in
// decreasing finishing order measures each component. A descent to a new vertex
// reads one matrix row, a return to a parent reads the stack and then the parent's
// row, and the scan for roots visits each vertex in turn.
// Results appear one per strobe cycle, in ascending leader order; the receiver
// cannot stall them. After the last result the block clears the matrices and
// then accepts the next graph. Reset runs the same clearing pass with busy high.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the vertex
// count and is always ready; it is meant to be written while idle.
module strongly_connected_component_sizes
	import scc_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  edge_item_t         item,
	output logic               strobe,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FIELD_W-1:0] cfg_data
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int SW = $clog2(MAX_VERTICES + 1);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_LOAD_WR = 4'd2;
	localparam logic [3:0] S_ROOT    = 4'd3;
	localparam logic [3:0] S_P2_ROOT = 4'd4;
	localparam logic [3:0] S_ROW     = 4'd5;
	localparam logic [3:0] S_POP     = 4'd6;
	localparam logic [3:0] S_OUT_RD  = 4'd7;
	localparam logic [3:0] S_OUT_EM  = 4'd8;

	logic [3:0]              state_q, state_d;
	logic [FIELD_W-1:0]      nv_q;
	logic [EW-1:0]           ecount_q, ecount_d;
	logic                    drop_q, drop_d;
	logic [MAX_VERTICES-1:0] explored_q, explored_d;
	logic [MAX_VERTICES-1:0] leader_q, leader_d;
	logic                    pass_q, pass_d;
	logic [VW-1:0]           k_q, k_d;
	logic [VW-1:0]           cur_q, cur_d;
	logic [VW-1:0]           root_q, root_d;
	logic [VW-1:0]           sp_q, sp_d;
	logic [VW-1:0]           fc_q, fc_d;
	logic [SW-1:0]           csize_q, csize_d;
	logic [VW-1:0]           tl_s1, tl_d, hd_s1, hd_d;
	logic                    ok_s1, ok_d, last_s1, last_d;

	// Memory ports.
	logic                    mat_we;
	logic [VW-1:0]           pred_waddr, succ_waddr, row_raddr, succ_raddr;
	logic [MAX_VERTICES-1:0] pred_wdata, succ_wdata, pred_rd, succ_rd;
	logic                    fin_we, stk_we, size_we;
	logic                    pred_we, succ_we;
	logic [VW-1:0]           fin_waddr, fin_raddr, fin_rd;
	logic [VW-1:0]           stk_waddr, stk_raddr, stk_rd;
	logic [VW-1:0]           size_waddr, size_raddr;
	logic [SW-1:0]           size_rd;

	// Effective vertex count and its mask.
	logic [FIELD_W-1:0]      neff;
	logic [VW-1:0]           nlast;
	logic [MAX_VERTICES-1:0] vmask, hi_mask;
	logic [MAX_VERTICES-1:0] row, cand;
	logic [VW-1:0]           w_idx;
	logic                    in_ok;

	always_comb begin
		if (nv_q == '0) begin
			neff = FIELD_W'(1);
		end else if (nv_q > FIELD_W'(MAX_VERTICES)) begin
			neff = FIELD_W'(MAX_VERTICES);
		end else begin
			neff = nv_q;
		end
		nlast = VW'(neff - FIELD_W'(1));
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vmask[i]   = (FIELD_W'(i) < neff);
			hi_mask[i] = (VW'(i) > k_q);
		end
	end

	// Next unexplored neighbor: the lowest numbered one, matching the order
	// in which the walk would first meet an unexplored neighbor.
	always_comb begin
		row   = pass_q ? succ_rd : pred_rd;
		cand  = row & ~explored_q & vmask;
		w_idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				w_idx = VW'(i);
			end
		end
	end

	assign in_ok = (item.tail_vertex != '0) && (item.tail_vertex <= neff) &&
		(item.head_vertex != '0) && (item.head_vertex <= neff) &&
		(ecount_q != EW'(MAX_EDGES));

	always_comb begin
		state_d    = state_q;
		ecount_d   = ecount_q;
		drop_d     = drop_q;
		explored_d = explored_q;
		leader_d   = leader_q;
		pass_d     = pass_q;
		k_d        = k_q;
		cur_d      = cur_q;
		root_d     = root_q;
		sp_d       = sp_q;
		fc_d       = fc_q;
		csize_d    = csize_q;
		tl_d       = tl_s1;
		hd_d       = hd_s1;
		ok_d       = ok_s1;
		last_d     = last_s1;
		mat_we     = 1'b0;
		pred_waddr = k_q;
		succ_waddr = k_q;
		pred_wdata = '0;
		succ_wdata = '0;
		row_raddr  = cur_q;
		succ_raddr = cur_q;
		fin_we     = 1'b0;
		fin_waddr  = fc_q;
		fin_raddr  = k_q;
		stk_we     = 1'b0;
		stk_waddr  = sp_q;
		stk_raddr  = sp_q - VW'(1);
		size_we    = 1'b0;
		size_waddr = root_q;
		size_raddr = k_q;
		strobe     = 1'b0;
		result     = '0;

		unique case (state_q)
			S_CLEAR: begin
				mat_we = 1'b1;
				if (k_q == VW'(MAX_VERTICES - 1)) begin
					state_d  = S_IDLE;
					ecount_d = '0;
					drop_d   = 1'b0;
				end else begin
					k_d = k_q + VW'(1);
				end
			end
			S_IDLE: begin
				tl_d       = VW'(item.tail_vertex - FIELD_W'(1));
				hd_d       = VW'(item.head_vertex - FIELD_W'(1));
				row_raddr  = VW'(item.head_vertex - FIELD_W'(1));
				succ_raddr = VW'(item.tail_vertex - FIELD_W'(1));
				ok_d       = in_ok;
				last_d     = item.last_edge;
				if (start) begin
					state_d = S_LOAD_WR;
				end
			end
			S_LOAD_WR: begin
				mat_we     = ok_s1;
				pred_waddr = hd_s1;
				succ_waddr = tl_s1;
				pred_wdata = pred_rd | (MAX_VERTICES'(1) << tl_s1);
				succ_wdata = succ_rd | (MAX_VERTICES'(1) << hd_s1);
				if (ok_s1) begin
					ecount_d = ecount_q + EW'(1);
				end else begin
					drop_d = 1'b1;
				end
				if (last_s1) begin
					state_d    = S_ROOT;
					explored_d = '0;
					leader_d   = '0;
					pass_d     = 1'b0;
					k_d        = nlast;
					fc_d       = '0;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ROOT: begin
				if (!explored_q[k_q]) begin
					explored_d[k_q] = 1'b1;
					cur_d           = k_q;
					sp_d            = '0;
					row_raddr       = k_q;
					state_d         = S_ROW;
				end else if (k_q == '0) begin
					explored_d = '0;
					pass_d     = 1'b1;
					k_d        = nlast;
					fin_raddr  = nlast;
					state_d    = S_P2_ROOT;
				end else begin
					k_d = k_q - VW'(1);
				end
			end
			S_P2_ROOT: begin
				if (!explored_q[fin_rd]) begin
					explored_d[fin_rd] = 1'b1;
					cur_d              = fin_rd;
					root_d             = fin_rd;
					sp_d               = '0;
					csize_d            = SW'(1);
					succ_raddr         = fin_rd;
					state_d            = S_ROW;
				end else if (k_q == '0) begin
					k_d     = '0;
					state_d = S_OUT_RD;
				end else begin
					k_d       = k_q - VW'(1);
					fin_raddr = k_q - VW'(1);
				end
			end
			S_ROW: begin
				if (cand != '0) begin
					stk_we            = 1'b1;
					sp_d              = sp_q + VW'(1);
					explored_d[w_idx] = 1'b1;
					cur_d             = w_idx;
					row_raddr         = w_idx;
					succ_raddr        = w_idx;
					if (pass_q) begin
						csize_d = csize_q + SW'(1);
					end
				end else begin
					if (!pass_q) begin
						fin_we = 1'b1;
						fc_d   = fc_q + VW'(1);
					end
					if (sp_q == '0) begin
						if (pass_q) begin
							size_we          = 1'b1;
							leader_d[root_q] = 1'b1;
							state_d          = S_P2_ROOT;
						end else begin
							state_d = S_ROOT;
						end
					end else begin
						sp_d    = sp_q - VW'(1);
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				cur_d      = stk_rd;
				row_raddr  = stk_rd;
				succ_raddr = stk_rd;
				state_d    = S_ROW;
			end
			S_OUT_RD: begin
				state_d = S_OUT_EM;
			end
			S_OUT_EM: begin
				if (leader_q[k_q]) begin
					strobe                = 1'b1;
					result.component_size = FIELD_W'(size_rd);
					result.last_component = ((leader_q & hi_mask) == '0);
					result.edges_dropped  = drop_q;
				end
				if (k_q == nlast) begin
					k_d     = '0;
					state_d = S_CLEAR;
				end else begin
					k_d     = k_q + VW'(1);
					state_d = S_OUT_RD;
				end
			end
			default: begin
				state_d = S_CLEAR;
				k_d     = '0;
			end
		endcase
	end

	assign pred_we   = mat_we;
	assign succ_we   = mat_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			nv_q       <= FIELD_W'(64);
			ecount_q   <= '0;
			drop_q     <= 1'b0;
			explored_q <= '0;
			leader_q   <= '0;
			pass_q     <= 1'b0;
			k_q        <= '0;
			cur_q      <= '0;
			root_q     <= '0;
			sp_q       <= '0;
			fc_q       <= '0;
			csize_q    <= '0;
			ok_s1      <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			state_q    <= state_d;
			ecount_q   <= ecount_d;
			drop_q     <= drop_d;
			explored_q <= explored_d;
			leader_q   <= leader_d;
			pass_q     <= pass_d;
			k_q        <= k_d;
			cur_q      <= cur_d;
			root_q     <= root_d;
			sp_q       <= sp_d;
			fc_q       <= fc_d;
			csize_q    <= csize_d;
			ok_s1      <= ok_d;
			last_s1    <= last_d;
			if (cfg_valid && cfg_ready) begin
				nv_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		tl_s1 <= tl_d;
		hd_s1 <= hd_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Predecessor rows: row h holds bit t for each stored edge t -> h.
	scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_pred (
		.clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
		.raddr(row_raddr), .rdata(pred_rd)
	);

	// Successor rows: row t holds bit h for each stored edge t -> h.
	scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_succ (
		.clk(clk), .we(succ_we), .waddr(succ_waddr), .wdata(succ_wdata),
		.raddr(succ_raddr), .rdata(succ_rd)
	);

	scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
		.clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(cur_q),
		.raddr(fin_raddr), .rdata(fin_rd)
	);

	scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(cur_q),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_size (
		.clk(clk), .we(size_we), .waddr(size_waddr), .wdata(csize_q),
		.raddr(size_raddr), .rdata(size_rd)
	);

endmodule

// ----- hw/rtl/scc_checker.sv -----
// Port-level checks for the strongly connected component size block.
// Depends on scc_pkg; bound to the top level below.
module scc_checker
	import scc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               strobe,
	input result_t            result
);

	// Results only come out of a running computation.
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("result strobe while idle");

	// An accepted item always raises busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("block idle right after accepting an item");

	// Result strobes never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n) strobe |=> !strobe)
		else $error("back to back result strobes");

	// Every component holds at least one vertex.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.component_size != '0))
		else $error("empty component reported");

endmodule

bind strongly_connected_component_sizes scc_checker u_scc_checker (.*);

// ----- sim/strongly_connected_component_sizes_tb.sv -----
`timescale 1ns / 100ps
// Testbench for strongly_connected_component_sizes: random and directed edge graphs,
// with component sizes predicted by a Kosaraju model inside a scoreboard class.
// Depends on scc_pkg and the block's RTL.
module strongly_connected_component_sizes_tb;
	import scc_pkg::*;

	localparam int MAX_V = 64;
	localparam int MAX_E = 256;
	localparam int N_ITEMS = 400;

	// Scoreboard: keeps its own copy of the vertex count and the edge store,
	// computes the component sizes when the last edge of a graph is accepted,
	// and checks each strobed result against the oldest expected one.
	class scc_scoreboard;
		bit [6:0] vertex_count = 7'd64;
		int tails[$];
		int heads[$];
		bit dropped;
		result_t sizes_q[$];
		int errors;
		int fwd_adj[MAX_V+1][$];
		int rev_adj[MAX_V+1][$];
		bit seen[MAX_V+1];
		int finish_at[MAX_V+1];
		int leader[MAX_V+1];
		int finished;

		function int eff_n();
			if (vertex_count < 1) return 1;
			if (vertex_count > MAX_V) return MAX_V;
			return vertex_count;
		endfunction

		// Iterative depth-first walk. The first pass follows reversed edges and
		// records finishing order; the second follows forward edges and labels leaders.
		function void walk(int root, bit second);
			int vs[$];
			int cs[$];
			int v;
			int c;
			int w;
			int deg;
			seen[root] = 1'b1;
			if (second) leader[root] = root;
			vs.insert(vs.size(), root);
			cs.insert(cs.size(), 0);
			while (vs.size() > 0) begin
				v = vs[vs.size()-1];
				c = cs[cs.size()-1];
				deg = second ? fwd_adj[v].size() : rev_adj[v].size();
				if (c < deg) begin
					w = second ? fwd_adj[v][c] : rev_adj[v][c];
					cs[cs.size()-1] = c + 1;
					if (!seen[w] && vs.size() < MAX_V) begin
						seen[w] = 1'b1;
						if (second) leader[w] = root;
						vs.insert(vs.size(), w);
						cs.insert(cs.size(), 0);
					end
				end else begin
					void'(vs.pop_back());
					void'(cs.pop_back());
					if (finished < MAX_V) finished++;
					if (!second) finish_at[finished] = v;
				end
			end
		endfunction

		function void compute_sizes();
			int n;
			int cnt[MAX_V+1];
			result_t r;
			int u;
			n = eff_n();
			for (int k = 0; k <= MAX_V; k++) begin
				fwd_adj[k].delete();
				rev_adj[k].delete();
				seen[k] = 1'b0;
				finish_at[k] = 0;
				leader[k] = 0;
				cnt[k] = 0;
			end
			// Edges that a later shrink of the vertex count put out of range are skipped.
			foreach (tails[k])
				if (tails[k] <= n && heads[k] <= n)
					fwd_adj[tails[k]].insert(fwd_adj[tails[k]].size(), heads[k]);
			// Reversed neighbors come by ascending tail, then by arrival.
			for (int t = 1; t <= n; t++)
				foreach (tails[k])
					if (tails[k] == t && heads[k] <= n)
						rev_adj[heads[k]].insert(rev_adj[heads[k]].size(), t);
			finished = 0;
			for (int k = n; k >= 1; k--)
				if (!seen[k]) walk(k, 1'b0);
			for (int k = 0; k <= MAX_V; k++) seen[k] = 1'b0;
			finished = 0;
			for (int k = n; k >= 1; k--) begin
				u = finish_at[k];
				if (u >= 1 && u <= n && !seen[u]) walk(u, 1'b1);
			end
			for (int k = 1; k <= n; k++) cnt[leader[k]]++;
			for (int k = 1; k <= n; k++) begin
				if (cnt[k] != 0) begin
					r.component_size = FIELD_W'(cnt[k]);
					r.last_component = 1'b0;
					r.edges_dropped = dropped;
					sizes_q.insert(sizes_q.size(), r);
				end
			end
			sizes_q[sizes_q.size()-1].last_component = 1'b1;
			tails.delete();
			heads.delete();
			dropped = 1'b0;
		endfunction

		function void note_edge(edge_item_t e);
			int n;
			n = eff_n();
			if (e.tail_vertex < 1 || e.tail_vertex > n || e.head_vertex < 1 ||
					e.head_vertex > n || tails.size() >= MAX_E) begin
				dropped = 1'b1;
			end else begin
				tails.insert(tails.size(), e.tail_vertex);
				heads.insert(heads.size(), e.head_vertex);
			end
			if (e.last_edge) compute_sizes();
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (sizes_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = sizes_q.pop_front();
			if (got.component_size != want.component_size) begin
				$display("%0t: component_size expected %0d actual %0d", $time,
					want.component_size, got.component_size);
				errors++;
			end
			if (got.last_component != want.last_component) begin
				$display("%0t: last_component expected %0b actual %0b", $time,
					want.last_component, got.last_component);
				errors++;
			end
			if (got.edges_dropped != want.edges_dropped) begin
				$display("%0t: edges_dropped expected %0b actual %0b", $time,
					want.edges_dropped, got.edges_dropped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	edge_item_t item = '0;
	logic strobe;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [FIELD_W-1:0] cfg_data = '0;

	scc_scoreboard sb = new();
	int sent;
	int burst_left;

	strongly_connected_component_sizes DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Results cannot be held off, so every strobe is checked as it comes.
	always @(posedge clk) begin
		if (arst_n && strobe) sb.check_result(result);
	end

	// Present one edge item; start stays high afterward so back-to-back items
	// keep it asserted. The item is taken at the first rising edge with busy low.
	task automatic send_edge(int t, int h, bit last);
		@(negedge clk);
		start = 1'b1;
		item.tail_vertex = FIELD_W'(t);
		item.head_vertex = FIELD_W'(h);
		item.last_edge = last;
		do @(posedge clk); while (busy);
		sb.note_edge(item);
		sent++;
		// Sender works in bursts separated by random gaps.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// Wait until every expected size has come and the clearing pass is over.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.sizes_q.size() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_count(int v);
		drain();
		cfg_valid = 1'b1;
		cfg_data = FIELD_W'(v);
		do @(posedge clk); while (!cfg_ready);
		sb.vertex_count = 7'(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random graph on the vertex count set by the caller (mostly small, a few full size),
	// with a little noise in the endpoints so that dropped edges show up now and then.
	task automatic random_graph();
		int n;
		int m;
		int t;
		int h;
		n = sb.eff_n();
		m = $urandom_range(1, 3 * n < 24 ? 3 * n : 24);
		for (int k = 0; k < m; k++) begin
			t = $urandom_range(1, n);
			h = $urandom_range(1, n);
			if ($urandom_range(0, 29) == 0) t = $urandom_range(0, 127);
			if ($urandom_range(0, 29) == 0) h = $urandom_range(0, 127);
			send_edge(t, h, k == m - 1);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Full vertex count: a pair of opposite edges, a self loop, out-of-range
		// endpoints and a valid edge marked last, which starts the computation.
		send_edge(1, 64, 0);
		send_edge(64, 1, 0);
		send_edge(64, 64, 0);
		send_edge(0, 5, 0);
		send_edge(65, 2, 0);
		send_edge(127, 127, 0);
		send_edge(3, 4, 1);
		// Smallest vertex count, then zero which acts as one.
		write_count(1);
		send_edge(1, 1, 1);
		write_count(0);
		send_edge(1, 2, 1);
		// Count above the maximum acts as the maximum; shrinking it mid-graph
		// makes the earlier high edge invisible at computation time.
		write_count(127);
		send_edge(64, 63, 0);
		write_count(5);
		send_edge(1, 2, 0);
		send_edge(2, 3, 0);
		send_edge(3, 1, 0);
		send_edge(4, 5, 1);
		write_count(64);
		send_edge(42, 21, 0);
		send_edge(21, 42, 1);

		// Store overflow: more edges than the store holds.
		write_count(8);
		for (int k = 0; k < MAX_E + 3; k++)
			send_edge($urandom_range(1, 8), $urandom_range(1, 8), k == MAX_E + 2);

		while (sent < N_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: write_count(64);
					1: write_count($urandom_range(64, 127));
					2: write_count(1);
					default: write_count($urandom_range(2, 12));
				endcase
			end
			if ($urandom_range(0, 7) == 0) drain();
			random_graph();
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("strongly_connected_component_sizes_tb OK");
		else
			$display("strongly_connected_component_sizes_tb NOT OK");
		$finish;
	end

	initial begin
		#20000000;
		$display("strongly_connected_component_sizes_tb NOT OK");
		$finish;
	end

endmodule
